/* hw/rtl/pce_pkg.sv */
// Shared types and codes for the correlation engine.
package pce_pkg;

    typedef struct packed {
        logic signed [15:0] sample_x;
        logic signed [15:0] sample_y;
        logic               last_pair;
    } sample_item_t;

    typedef struct packed {
        logic signed [15:0] coefficient;
        logic [1:0]         status;
        logic [12:0]        pair_count;
    } result_item_t;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_FLAT   = 2'd1;
    localparam logic [1:0] STATUS_EXCESS = 2'd2;

    // product steps of the solver
    localparam logic [2:0] OP_N_SXX  = 3'd0;
    localparam logic [2:0] OP_SX_SX  = 3'd1;
    localparam logic [2:0] OP_N_SYY  = 3'd2;
    localparam logic [2:0] OP_SY_SY  = 3'd3;
    localparam logic [2:0] OP_N_SXY  = 3'd4;
    localparam logic [2:0] OP_SX_SY  = 3'd5;
    localparam logic [2:0] OP_NUM_SQ = 3'd6;
    localparam logic [2:0] OP_DEN    = 3'd7;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LAUNCH,
        BK_WAIT,
        BK_TLAUNCH,
        BK_TWAIT,
        BK_EMIT
    } back_state_t;

endpackage

/* hw/rtl/pearson_correlation_engine_core.sv */
// Top level of the Pearson correlation engine: front, queue, solver, result register.
//
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+---------------------------
//  sample   | sample_valid | sample_ready | sample_item (x, y, last)
//  result   | result_valid | result_ready | result_item (r, status, n)
//
// Pairs are summed at one per cycle while sample_ready is high. After the pair marked
// last, the solver runs eight shift-add products and sixteen trial products when the
// coefficient is solved; a degenerate vector stops after the fourth product, and a
// short or overfull vector is reported without any product. The two-entry queue lets
// the next vector accumulate meanwhile; sample_ready drops only while two finished
// vectors wait. Reset clears the front-end sums and the control state.
module pearson_correlation_engine_core #(
    parameter int MAX_SAMPLES = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sample_valid,
    output logic                    sample_ready,
    input  pce_pkg::sample_item_t   sample_item,
    output logic                    result_valid,
    input  logic                    result_ready,
    output pce_pkg::result_item_t   result_item
);
    import pce_pkg::*;

    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int SUMW = SAMPLE_BITS + CW;
    localparam int SQW  = 2 * SAMPLE_BITS + CW;
    localparam int DW   = 2 * SAMPLE_BITS + 2 * CW;
    localparam int LW   = 2 * DW + 34;
    localparam int MBW  = (DW > 34) ? DW : 34;
    localparam int JW   = 1 + CW + 2 * SUMW + 3 * SQW;

    logic          full, push, not_empty, pop;
    logic [JW-1:0] job_in, job_out;
    logic          res_valid, res_take;
    result_item_t  res_item;

    logic          out_valid_reg;
    result_item_t  out_item_reg;

    pce_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CW          (CW),
        .SUMW        (SUMW),
        .SQW         (SQW),
        .JW          (JW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_item  (sample_item),
        .full         (full),
        .push         (push),
        .job          (job_in)
    );

    pce_queue #(
        .W (JW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata     (job_in),
        .pop       (pop),
        .rdata     (job_out),
        .full      (full),
        .not_empty (not_empty)
    );

    pce_back #(
        .CW   (CW),
        .SUMW (SUMW),
        .SQW  (SQW),
        .DW   (DW),
        .LW   (LW),
        .MBW  (MBW),
        .JW   (JW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (not_empty),
        .job       (job_out),
        .pop       (pop),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res_item  (res_item)
    );

    assign res_take     = res_valid && (!out_valid_reg || result_ready);
    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_item_reg <= res_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

/* hw/rtl/pce_front.sv */
// Front end: takes pairs, keeps running sums, hands finished vectors to the queue.
module pce_front #(
    parameter int MAX_SAMPLES = 4096,
    parameter int SAMPLE_BITS = 16,
    parameter int CW          = 13,
    parameter int SUMW        = 29,
    parameter int SQW         = 45,
    parameter int JW          = 1 + 13 + 2 * 29 + 3 * 45
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sample_valid,
    output logic                    sample_ready,
    input  pce_pkg::sample_item_t   sample_item,
    input  logic                    full,
    output logic                    push,
    output logic [JW-1:0]           job
);
    import pce_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int EXTW = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;

    logic [CW-1:0]          count_reg;
    logic signed [SUMW-1:0] sx_reg, sy_reg;
    logic signed [SQW-1:0]  sxx_reg, syy_reg, sxy_reg;
    logic                   excess_reg;

    logic [EXTW-1:0]        x_ext, y_ext;
    logic signed [SB-1:0]   xs, ys;
    logic signed [2*SB-1:0] xx, yy, xy;
    logic                   take, room;

    logic [CW-1:0]          count_next;
    logic signed [SUMW-1:0] sx_next, sy_next;
    logic signed [SQW-1:0]  sxx_next, syy_next, sxy_next;
    logic                   excess_next;

    assign sample_ready = !full;
    assign take         = sample_valid && sample_ready;

    // field bits above the sample width are dropped; a narrow field zero-extends
    assign x_ext = EXTW'($unsigned(sample_item.sample_x));
    assign y_ext = EXTW'($unsigned(sample_item.sample_y));
    assign xs    = $signed(x_ext[SB-1:0]);
    assign ys    = $signed(y_ext[SB-1:0]);
    assign xx    = xs * xs;
    assign yy    = ys * ys;
    assign xy    = xs * ys;

    assign room = count_reg < CW'(MAX_SAMPLES);

    always_comb
    begin
        count_next  = count_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        sxx_next    = sxx_reg;
        syy_next    = syy_reg;
        sxy_next    = sxy_reg;
        excess_next = excess_reg;
        if (room)
        begin
            count_next = count_reg + CW'(1);
            sx_next    = sx_reg + SUMW'(xs);
            sy_next    = sy_reg + SUMW'(ys);
            sxx_next   = sxx_reg + SQW'(xx);
            syy_next   = syy_reg + SQW'(yy);
            sxy_next   = sxy_reg + SQW'(xy);
        end
        else
        begin
            excess_next = 1'b1;
        end
    end

    assign push = take && sample_item.last_pair;
    assign job  = {excess_next, count_next, sx_next, sy_next, sxx_next, syy_next, sxy_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sx_reg     <= '0;
            sy_reg     <= '0;
            sxx_reg    <= '0;
            syy_reg    <= '0;
            sxy_reg    <= '0;
            excess_reg <= 1'b0;
        end
        else if (take)
        begin
            if (sample_item.last_pair)
            begin
                count_reg  <= '0;
                sx_reg     <= '0;
                sy_reg     <= '0;
                sxx_reg    <= '0;
                syy_reg    <= '0;
                sxy_reg    <= '0;
                excess_reg <= 1'b0;
            end
            else
            begin
                count_reg  <= count_next;
                sx_reg     <= sx_next;
                sy_reg     <= sy_next;
                sxx_reg    <= sxx_next;
                syy_reg    <= syy_next;
                sxy_reg    <= sxy_next;
                excess_reg <= excess_next;
            end
        end
    end

endmodule

/* hw/rtl/pce_queue.sv */
// Two-entry queue of finished vector sums between front and back.
module pce_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         full,
    output logic         not_empty
);
    logic [W-1:0] data_reg [2];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   cnt_reg;

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign rdata     = data_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

/* hw/rtl/pce_mul.sv */
// Shift-add multiplier, one multiplier bit per cycle, stops when the rest is zero.
module pce_mul #(
    parameter int LW  = 152,
    parameter int MBW = 59
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [LW-1:0]  a,
    input  logic [MBW-1:0] b,
    output logic           done,
    output logic [LW-1:0]  acc
);
    logic [LW-1:0]  a_reg, acc_reg;
    logic [MBW-1:0] b_reg;
    logic           busy_reg;

    assign done = busy_reg && (b_reg == '0);
    assign acc  = acc_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg && (b_reg != '0))
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[LW-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[MBW-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

endmodule

/* hw/rtl/pce_back.sv */
// Back end: forms the centered sums and searches the Q1.15 coefficient bit by bit.
module pce_back #(
    parameter int CW   = 13,
    parameter int SUMW = 29,
    parameter int SQW  = 45,
    parameter int DW   = 58,
    parameter int LW   = 150,
    parameter int MBW  = 58,
    parameter int JW   = 1 + 13 + 2 * 29 + 3 * 45
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    job_valid,
    input  logic [JW-1:0]           job,
    output logic                    pop,
    output logic                    res_valid,
    input  logic                    res_take,
    output pce_pkg::result_item_t   res_item
);
    import pce_pkg::*;

    localparam int O_SYY = SQW;
    localparam int O_SXX = 2 * SQW;
    localparam int O_SY  = 3 * SQW;
    localparam int O_SX  = 3 * SQW + SUMW;
    localparam int O_N   = 3 * SQW + 2 * SUMW;

    back_state_t state_reg, state_next;

    logic [CW-1:0]          n_reg;
    logic signed [SUMW-1:0] sx_reg, sy_reg;
    logic signed [SQW-1:0]  sxx_reg, syy_reg, sxy_reg;
    logic signed [DW-1:0]   pa_reg, dx_reg, dy_reg, num_reg;
    logic [LW-1:0]          rhs_reg, den_reg;
    logic [15:0]            q_reg;
    logic [3:0]             bit_reg;
    logic [2:0]             op_reg;
    logic                   neg_reg;
    logic [1:0]             status_reg;
    logic signed [15:0]     coef_reg;

    logic [CW-1:0]          job_n;
    logic                   job_excess, job_short;

    logic                   mul_start, mul_done;
    logic [LW-1:0]          mul_a, mul_acc;
    logic [MBW-1:0]         mul_b;
    logic                   op_neg;

    logic [SUMW-1:0]        mag_sx, mag_sy;
    logic [SQW-1:0]         mag_sxy;
    logic [DW-1:0]          mag_num;
    logic signed [DW-1:0]   sres, diff;

    logic [15:0]            cand, q_new;
    logic [16:0]            t_odd;
    logic [33:0]            t_sq;
    logic                   fit;
    logic signed [15:0]     coef_new;

    assign job_n      = job[O_N +: CW];
    assign job_excess = job[JW-1];
    assign job_short  = job_n < CW'(2);

    assign mag_sx  = sx_reg[SUMW-1] ? $unsigned(-sx_reg) : $unsigned(sx_reg);
    assign mag_sy  = sy_reg[SUMW-1] ? $unsigned(-sy_reg) : $unsigned(sy_reg);
    assign mag_sxy = sxy_reg[SQW-1] ? $unsigned(-sxy_reg) : $unsigned(sxy_reg);
    assign mag_num = num_reg[DW-1] ? $unsigned(-num_reg) : $unsigned(num_reg);

    // trial code: (2*cand - 1)^2 scaled against the denominator
    assign cand  = q_reg | (16'd1 << bit_reg);
    assign t_odd = {cand, 1'b0} - 17'd1;
    assign t_sq  = t_odd * t_odd;

    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        op_neg = 1'b0;
        if (state_reg == BK_TLAUNCH)
        begin
            mul_a = den_reg;
            mul_b = MBW'(t_sq);
        end
        else
        begin
            case (op_reg)
                OP_N_SXX:
                begin
                    mul_a = LW'($unsigned(sxx_reg));
                    mul_b = MBW'(n_reg);
                end
                OP_SX_SX:
                begin
                    mul_a = LW'(mag_sx);
                    mul_b = MBW'(mag_sx);
                end
                OP_N_SYY:
                begin
                    mul_a = LW'($unsigned(syy_reg));
                    mul_b = MBW'(n_reg);
                end
                OP_SY_SY:
                begin
                    mul_a = LW'(mag_sy);
                    mul_b = MBW'(mag_sy);
                end
                OP_N_SXY:
                begin
                    mul_a  = LW'(mag_sxy);
                    mul_b  = MBW'(n_reg);
                    op_neg = sxy_reg[SQW-1];
                end
                OP_SX_SY:
                begin
                    mul_a  = LW'(mag_sx);
                    mul_b  = MBW'(mag_sy);
                    op_neg = sx_reg[SUMW-1] ^ sy_reg[SUMW-1];
                end
                OP_NUM_SQ:
                begin
                    mul_a = LW'(mag_num);
                    mul_b = MBW'(mag_num);
                end
                default:
                begin
                    mul_a = LW'($unsigned(dx_reg));
                    mul_b = MBW'($unsigned(dy_reg));
                end
            endcase
        end
    end

    pce_mul #(
        .LW  (LW),
        .MBW (MBW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .acc   (mul_acc)
    );

    assign sres = neg_reg ? -$signed(mul_acc[DW-1:0]) : $signed(mul_acc[DW-1:0]);
    assign diff = pa_reg - sres;

    assign fit      = mul_acc <= rhs_reg;
    assign q_new    = fit ? cand : q_reg;
    assign coef_new = num_reg[DW-1] ? $signed(16'(17'd0 - {1'b0, q_new}))
                    : (q_new[15] ? 16'sd32767 : $signed(q_new));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = (job_excess || job_short) ? BK_EMIT : BK_LAUNCH;
                end
            end
            BK_LAUNCH:
            begin
                state_next = BK_WAIT;
            end
            BK_WAIT:
            begin
                if (mul_done)
                begin
                    if (op_reg == OP_SY_SY && (dx_reg <= 0 || diff <= 0))
                    begin
                        state_next = BK_EMIT;
                    end
                    else if (op_reg == OP_DEN)
                    begin
                        state_next = BK_TLAUNCH;
                    end
                    else
                    begin
                        state_next = BK_LAUNCH;
                    end
                end
            end
            BK_TLAUNCH:
            begin
                state_next = BK_TWAIT;
            end
            BK_TWAIT:
            begin
                if (mul_done)
                begin
                    state_next = (bit_reg == 4'd0) ? BK_EMIT : BK_TLAUNCH;
                end
            end
            BK_EMIT:
            begin
                if (res_take)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        mul_start = 1'b0;
        res_valid = 1'b0;
        unique case (state_reg)
            BK_IDLE:    pop       = job_valid;
            BK_LAUNCH:  mul_start = 1'b1;
            BK_TLAUNCH: mul_start = 1'b1;
            BK_EMIT:    res_valid = 1'b1;
            default:    pop       = 1'b0;
        endcase
    end

    assign res_item.coefficient = coef_reg;
    assign res_item.status      = status_reg;
    assign res_item.pair_count  = 13'(n_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    n_reg    <= job_n;
                    sx_reg   <= job[O_SX +: SUMW];
                    sy_reg   <= job[O_SY +: SUMW];
                    sxx_reg  <= job[O_SXX +: SQW];
                    syy_reg  <= job[O_SYY +: SQW];
                    sxy_reg  <= job[SQW-1:0];
                    op_reg   <= OP_N_SXX;
                    coef_reg <= '0;
                    if (job_excess)
                    begin
                        status_reg <= STATUS_EXCESS;
                    end
                    else if (job_short)
                    begin
                        status_reg <= STATUS_FLAT;
                    end
                    else
                    begin
                        status_reg <= STATUS_OK;
                    end
                end
            end
            BK_LAUNCH:
            begin
                neg_reg <= op_neg;
            end
            BK_WAIT:
            begin
                if (mul_done)
                begin
                    op_reg <= op_reg + 3'd1;
                    case (op_reg)
                        OP_N_SXX, OP_N_SYY, OP_N_SXY: pa_reg  <= sres;
                        OP_SX_SX:                     dx_reg  <= diff;
                        OP_SY_SY:
                        begin
                            dy_reg <= diff;
                            if (dx_reg <= 0 || diff <= 0)
                            begin
                                status_reg <= STATUS_FLAT;
                            end
                        end
                        OP_SX_SY:                     num_reg <= diff;
                        OP_NUM_SQ: rhs_reg <= {mul_acc[LW-33:0], 32'd0};
                        default:
                        begin
                            den_reg <= mul_acc;
                            q_reg   <= '0;
                            bit_reg <= 4'd15;
                        end
                    endcase
                end
            end
            BK_TWAIT:
            begin
                if (mul_done)
                begin
                    q_reg   <= q_new;
                    bit_reg <= bit_reg - 4'd1;
                    if (bit_reg == 4'd0)
                    begin
                        coef_reg <= coef_new;
                    end
                end
            end
            default:
            begin
                neg_reg <= neg_reg;
            end
        endcase
    end

endmodule

/* tb/sv/tb_top.sv */
// Testbench for the Pearson correlation engine: directed and random vectors, self-checking.
`timescale 1ns / 100ps

module tb_top;
    import pce_pkg::*;

    localparam int MAX_PAIRS     = 4096;
    localparam int STALL_LIMIT   = 200000;

    logic         clk;
    logic         rst_n;
    logic         sample_valid;
    logic         sample_ready;
    sample_item_t sample_item;
    logic         result_valid;
    logic         result_ready;
    result_item_t result_item;

    pearson_correlation_engine_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_item  (sample_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    // predictor state
    int unsigned     acc_n;
    longint          acc_x, acc_y, acc_xx, acc_yy, acc_xy;
    bit              acc_over;
    result_item_t    expected_results[$];

    int  mismatch_count;
    bit  failed;
    bit  idle_on;         // random idling enabled
    bit  sink_hold;       // receiver held off
    int  hold_cycles;
    int  quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // largest q with (2q-1)^2 * den <= 2^32 * num^2
    function automatic logic signed [15:0] solve_coef(logic signed [255:0] num,
                                                      logic signed [255:0] den);
        logic signed [255:0] mag;
        logic signed [255:0] rhs;
        logic signed [255:0] t;
        longint lo;
        longint hi;
        longint mid;
        mag = (num < 0) ? -num : num;
        rhs = (mag * mag) <<< 32;
        lo  = 0;
        hi  = 32768;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            t = 256'(2 * mid - 1);
            if (t * t * den <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        if (num < 0)
            return 16'(-lo);
        return (lo > 32767) ? 16'sd32767 : $signed(lo[15:0]);
    endfunction

    function automatic void predict_pair(sample_item_t it);
        longint x;
        longint y;
        logic signed [255:0] n, dx, dy, num;
        result_item_t r;
        x = longint'(it.sample_x);
        y = longint'(it.sample_y);
        if (acc_n < MAX_PAIRS)
        begin
            acc_x  += x;
            acc_y  += y;
            acc_xx += x * x;
            acc_yy += y * y;
            acc_xy += x * y;
            acc_n++;
        end
        else
            acc_over = 1'b1;
        if (!it.last_pair)
            return;
        r.coefficient = '0;
        r.pair_count  = acc_n[12:0];
        if (acc_over)
            r.status = STATUS_EXCESS;
        else
        begin
            n  = 256'(acc_n);
            dx = n * acc_xx - 256'(acc_x) * acc_x;
            dy = n * acc_yy - 256'(acc_y) * acc_y;
            if (acc_n < 2 || dx <= 0 || dy <= 0)
                r.status = STATUS_FLAT;
            else
            begin
                num = n * acc_xy - 256'(acc_x) * acc_y;
                r.status = STATUS_OK;
                r.coefficient = solve_coef(num, dx * dy);
            end
        end
        expected_results.push_back(r);
        acc_n = 0; acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xy = 0;
        acc_over = 1'b0;
    endfunction

    // valid drops only while idling, so back-to-back items keep it high
    task automatic send_pair(logic signed [15:0] x, logic signed [15:0] y, bit last);
        while (idle_on && $urandom_range(99) < 27)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample_item  <= '{sample_x: x, sample_y: y, last_pair: last};
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        predict_pair(sample_item);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        sample_valid <= 1'b0;
        @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic send_vector(int len, int mode);
        int i;
        int a;
        int b;
        for (i = 0; i < len; i++)
        begin
            a = $urandom;
            b = $urandom;
            case (mode)
                1: b = a;                       // perfectly correlated
                2: b = -a;                      // anti-correlated
                3: b = a + $urandom_range(7);   // nearly correlated
                default: ;
            endcase
            send_pair(a[15:0], b[15:0], i == len - 1);
        end
    endtask

    task automatic test_extremes();
        send_pair(16'sh7fff, 16'sh8000, 1'b0);
        send_pair(16'sh8000, 16'sh7fff, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b0);
        send_pair(16'sh7fff, 16'sh7fff, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b0);
        send_pair(16'sh8000, 16'sh8000, 1'b0);
        send_pair(16'sh7fff, 16'sh8000, 1'b1);
        send_pair(16'sh0000, 16'shffff, 1'b0);
        send_pair(16'sh5555, 16'shaaaa, 1'b0);
        send_pair(16'shaaaa, 16'sh5555, 1'b1);
    endtask

    task automatic test_degenerate();
        send_pair(16'sd5, 16'sd9, 1'b1);         // single pair
        send_pair(16'sd3, 16'sd1, 1'b0);         // flat x
        send_pair(16'sd3, 16'sd8, 1'b1);
        send_pair(16'sd1, -16'sd4, 1'b0);        // flat y
        send_pair(16'sd6, -16'sd4, 1'b1);
        send_pair(16'sd1, 16'sd2, 1'b0);
        send_pair(16'sd2, 16'sd5, 1'b0);
        send_pair(16'sd4, 16'sd3, 1'b1);
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_cycles = 3000;
        sink_hold   = 1'b1;
        repeat (8) send_vector(3 + $urandom_range(5), $urandom_range(3));
        wait_drained();                          // sender pauses until all arrived
        wait (sink_hold == 1'b0);
        repeat (50) @(negedge clk);
    endtask

    task automatic test_random();
        int sent;
        int len;
        sent = 0;
        while (sent < 1800)
        begin
            if (sent >= 900 && sent < 1100)
                idle_on = 1'b0;
            else
                idle_on = 1'b1;
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
            send_vector(len, $urandom_range(3));
            sent += len;
        end
        idle_on = 1'b1;
    endtask

    // receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (sink_hold)
        begin
            result_ready <= 1'b0;
            if (hold_cycles > 0)
                hold_cycles--;
            else
                sink_hold = 1'b0;
        end
        else
            result_ready <= !(idle_on && $urandom_range(99) < 27);
    end

    always @(posedge clk)
    begin
        result_item_t exp_r;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                failed = 1'b1;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: %p", result_item);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (result_item.coefficient !== exp_r.coefficient
                    || result_item.status !== exp_r.status
                    || result_item.pair_count !== exp_r.pair_count)
                begin
                    failed = 1'b1;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected r=%0d st=%0d n=%0d, got r=%0d st=%0d n=%0d",
                                 exp_r.coefficient, exp_r.status, exp_r.pair_count,
                                 result_item.coefficient, result_item.status,
                                 result_item.pair_count);
                end
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if ((sample_valid && sample_ready) || (result_valid && result_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample_item = '0;
        idle_on = 1'b1;
        sink_hold = 1'b0;
        hold_cycles = 0;
        mismatch_count = 0;
        failed = 1'b0;
        acc_n = 0; acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xy = 0;
        acc_over = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_degenerate();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (2000) @(negedge clk);
        if (!failed && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* pearson_correlation_engine_core.f */
hw/rtl/pce_pkg.sv
hw/rtl/pce_front.sv
hw/rtl/pce_queue.sv
hw/rtl/pce_mul.sv
hw/rtl/pce_back.sv
hw/rtl/pearson_correlation_engine_core.sv
tb/sv/tb_top.sv
